@@ hdl/modular_lagrange_interpolator_defines.svh @@
// assertion macros shared by the modular lagrange interpolator rtl
`ifndef MODULAR_LAGRANGE_INTERPOLATOR_DEFINES_SVH
`define MODULAR_LAGRANGE_INTERPOLATOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define MLI_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define MLI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mli_pkg.sv @@
// types, constants and modular helpers of the modular lagrange interpolator
`default_nettype none

package mli_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int VALUE_BITS  = 30;
   localparam int POWER_BITS  = 6;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int KW          = IDX_W + 1;
   localparam int WORK_AW     = IDX_W + 2;
   localparam int WORK_DEPTH  = 2 ** WORK_AW;
   localparam int STEP_W      = $clog2(VALUE_BITS);
   localparam logic [VALUE_BITS-1:0] MODULUS_RESET = VALUE_BITS'(998244353);

   typedef struct packed {
      logic [VALUE_BITS-1:0] x_coord;
      logic [VALUE_BITS-1:0] y_value;
      logic                  last_point;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] coefficient;
      logic [POWER_BITS-1:0] power_index;
      logic                  last_coefficient;
      logic                  repeated_x;
      logic                  points_dropped;
   } rsp_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] x;
      logic [VALUE_BITS-1:0] y;
   } pt_type;

   typedef enum logic [5:0] {
      S_IDLE, S_RX, S_RY,
      S_RR_RD, S_RR_X, S_RR_XW, S_RR_YW,
      S_RP_RDI, S_RP_LDI, S_RP_RDJ, S_RP_CMP,
      S_CLR_NP, S_CLR_CS,
      S_NP_RDJ, S_NP_LDJ, S_NP_RDK, S_NP_MUL, S_NP_WB,
      S_LI_RD, S_LI_LD, S_SD_RD, S_SD_MUL, S_SD_WB,
      S_DN_RD, S_DN_MUL, S_DN_WB,
      S_PW_CHK, S_PW_R, S_PW_B, S_SC_W,
      S_AC_RQ, S_AC_MUL, S_AC_LDC, S_AC_WB,
      S_OUT_RD, S_OUT_EM
   } mli_state_type;

   // a + b mod m, both operands below m
   function automatic logic [VALUE_BITS-1:0] add_mod(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b,
                                                     input logic [VALUE_BITS-1:0] m);
      logic [VALUE_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, m}) ? VALUE_BITS'(s - {1'b0, m}) : s[VALUE_BITS-1:0];
   endfunction

   // a - b mod m, both operands below m
   function automatic logic [VALUE_BITS-1:0] sub_mod(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b,
                                                     input logic [VALUE_BITS-1:0] m);
      return (a >= b) ? a - b : a - b + m;
   endfunction

endpackage

`default_nettype wire

@@ hdl/modular_lagrange_interpolator.sv @@
// top level of the modular lagrange interpolator: sequencer, point and work memories
// Use: sample points arrive one word per start pulse on req_word, accepted when
// start is high and busy is low. The word with last_point set closes the set.
// csr_write_en with csr_write_data sets the prime modulus (reset 998244353);
// write it only while busy is low and no result is pending.
// Every modular multiply runs in one shared bit-serial unit (one multiplier
// bit per cycle); all timing follows from that unit and the registered
// reads of the two memories.
// A point word that is not last keeps busy high while its x and y are reduced.
// The last word starts the solve, after which n coefficient words leave on
// rsp_word, lowest power first, each marked by rsp_strobe for one cycle.
// The receiver cannot stall; words must be taken as they appear. After the
// highest coefficient the point count and error flags clear and busy drops.
// Reset is synchronous and empties the point set; memory contents are not
// cleared and need no clearing pass.
`default_nettype none

module modular_lagrange_interpolator import mli_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_word_type          req_word,
   output logic                       rsp_strobe,
   output rsp_word_type               rsp_word,
   input  wire logic                  csr_write_en,
   input  wire logic [VALUE_BITS-1:0] csr_write_data
);

`include "modular_lagrange_interpolator_defines.svh"

   mli_state_type         state_ff, state_in;
   logic [KW-1:0]         cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic                  rep_ff, rep_in;
   logic [KW-1:0]         i_ff, i_in;
   logic [KW-1:0]         j_ff, j_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [VALUE_BITS-1:0] prime_ff;
   logic [VALUE_BITS-1:0] in_y_ff, in_y_in;
   logic                  in_last_ff, in_last_in;
   logic [VALUE_BITS-1:0] xi_ff, xi_in;
   logic [VALUE_BITS-1:0] yi_ff, yi_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] base_ff, base_in;
   logic [VALUE_BITS-1:0] exp_ff, exp_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] s_ff, s_in;
   rsp_word_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [VALUE_BITS-1:0] m_eff;
   logic [VALUE_BITS-1:0] one;
   logic [VALUE_BITS-1:0] nacc;
   logic [KW-1:0]         km1;

   logic                  mul_start;
   logic [VALUE_BITS-1:0] mul_a;
   logic [VALUE_BITS-1:0] mul_b;
   logic                  mul_done;
   logic [VALUE_BITS-1:0] mul_res;

   logic                  pts_we;
   logic [IDX_W-1:0]      pts_waddr;
   pt_type                pts_wdata;
   logic [IDX_W-1:0]      pts_raddr;
   pt_type                pts_rdata;
   logic [$bits(pt_type)-1:0] pts_rbits;

   logic                  work_we;
   logic [WORK_AW-1:0]    work_waddr;
   logic [VALUE_BITS-1:0] work_wdata;
   logic [WORK_AW-1:0]    work_raddr;
   logic [VALUE_BITS-1:0] work_rdata;

   // work memory regions: quotient, coefficient sums, node product
   function automatic logic [WORK_AW-1:0] q_addr(input logic [KW-1:0] k);
      return {2'b00, k[IDX_W-1:0]};
   endfunction

   function automatic logic [WORK_AW-1:0] cs_addr(input logic [KW-1:0] k);
      return {2'b01, k[IDX_W-1:0]};
   endfunction

   function automatic logic [WORK_AW-1:0] np_addr(input logic [KW-1:0] k);
      return {1'b1, k[IDX_W:0]};
   endfunction

   // effective modulus, zero acts as one
   assign m_eff = (prime_ff == '0) ? VALUE_BITS'(1) : prime_ff;
   assign one   = (m_eff == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
   assign nacc  = add_mod(mul_res, val_ff, m_eff);
   assign km1   = k_ff - 1'b1;

   // point store: x and y side by side
   mli_ram #(
      .WIDTH ($bits(pt_type)),
      .DEPTH (2 ** IDX_W)
   ) u_pts_ram (
      .clock (clock),
      .we    (pts_we),
      .waddr (pts_waddr),
      .wdata (pts_wdata),
      .raddr (pts_raddr),
      .rdata (pts_rbits)
   );
   assign pts_rdata = pt_type'(pts_rbits);

   // working store: quotient, coefficient sums and node product
   mli_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (WORK_DEPTH)
   ) u_work_ram (
      .clock (clock),
      .we    (work_we),
      .waddr (work_waddr),
      .wdata (work_wdata),
      .raddr (work_raddr),
      .rdata (work_rdata)
   );

   // shared modular multiplier
   mli_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .modulus (m_eff),
      .done    (mul_done),
      .product (mul_res)
   );

   // sequencer: next state, memory accesses and multiplier requests
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      rep_in       = rep_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      in_y_in      = in_y_ff;
      in_last_in   = in_last_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      prev_in      = prev_ff;
      val_in       = val_ff;
      s_in         = s_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mul_start    = 1'b0;
      mul_a        = one;
      mul_b        = '0;
      pts_we       = 1'b0;
      pts_waddr    = cnt_ff[IDX_W-1:0];
      pts_wdata    = '{x: val_ff, y: mul_res};
      pts_raddr    = i_ff[IDX_W-1:0];
      work_we      = 1'b0;
      work_waddr   = np_addr(k_ff);
      work_wdata   = '0;
      work_raddr   = np_addr(k_ff);

      unique case (state_ff)
         // take a point word
         S_IDLE: begin
            if (start) begin
               in_y_in    = req_word.y_value;
               in_last_in = req_word.last_point;
               if (cnt_ff < KW'(MAX_POINTS)) begin
                  mul_start = 1'b1;
                  mul_a     = one;
                  mul_b     = req_word.x_coord;
                  state_in  = S_RX;
               end else begin
                  ovf_in = 1'b1;
                  if (req_word.last_point) begin
                     i_in     = '0;
                     state_in = S_RR_RD;
                  end
               end
            end
         end
         // reduce x and y on entry, then store
         S_RX: begin
            if (mul_done) begin
               val_in    = mul_res;
               mul_start = 1'b1;
               mul_a     = one;
               mul_b     = in_y_ff;
               state_in  = S_RY;
            end
         end
         S_RY: begin
            if (mul_done) begin
               pts_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (in_last_ff) begin
                  i_in     = '0;
                  state_in = S_RR_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         // reduce stored points again under the current modulus
         S_RR_RD: begin
            if (i_ff == cnt_ff) begin
               i_in     = '0;
               state_in = S_RP_RDI;
            end else begin
               state_in = S_RR_X;
            end
         end
         S_RR_X: begin
            yi_in     = pts_rdata.y;
            mul_start = 1'b1;
            mul_b     = pts_rdata.x;
            state_in  = S_RR_XW;
         end
         S_RR_XW: begin
            if (mul_done) begin
               val_in    = mul_res;
               mul_start = 1'b1;
               mul_b     = yi_ff;
               state_in  = S_RR_YW;
            end
         end
         S_RR_YW: begin
            if (mul_done) begin
               pts_we    = 1'b1;
               pts_waddr = i_ff[IDX_W-1:0];
               i_in      = i_ff + 1'b1;
               state_in  = S_RR_RD;
            end
         end
         // pairwise search for a repeated x
         S_RP_RDI: begin
            if (i_ff == cnt_ff) begin
               k_in     = '0;
               state_in = S_CLR_NP;
            end else begin
               state_in = S_RP_LDI;
            end
         end
         S_RP_LDI: begin
            xi_in    = pts_rdata.x;
            j_in     = i_ff + 1'b1;
            state_in = S_RP_RDJ;
         end
         S_RP_RDJ: begin
            pts_raddr = j_ff[IDX_W-1:0];
            if (j_ff == cnt_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_RP_RDI;
            end else begin
               state_in = S_RP_CMP;
            end
         end
         S_RP_CMP: begin
            if (pts_rdata.x == xi_ff) begin
               rep_in   = 1'b1;
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_RP_RDJ;
            end
         end
         // seed the node product and clear the sums
         S_CLR_NP: begin
            work_we    = 1'b1;
            work_wdata = (k_ff == '0) ? one : '0;
            state_in   = S_CLR_CS;
         end
         S_CLR_CS: begin
            if (k_ff == cnt_ff) begin
               j_in     = '0;
               state_in = S_NP_RDJ;
            end else begin
               work_we    = 1'b1;
               work_waddr = cs_addr(k_ff);
               k_in       = k_ff + 1'b1;
               state_in   = S_CLR_NP;
            end
         end
         // node product: multiply in (t - x_j), low power upward
         S_NP_RDJ: begin
            pts_raddr = j_ff[IDX_W-1:0];
            if (j_ff == cnt_ff) begin
               i_in     = '0;
               state_in = S_LI_RD;
            end else begin
               state_in = S_NP_LDJ;
            end
         end
         S_NP_LDJ: begin
            xi_in    = pts_rdata.x;
            prev_in  = '0;
            k_in     = '0;
            state_in = S_NP_RDK;
         end
         S_NP_RDK: begin
            state_in = S_NP_MUL;
         end
         S_NP_MUL: begin
            val_in    = work_rdata;
            mul_start = 1'b1;
            mul_a     = work_rdata;
            mul_b     = xi_ff;
            state_in  = S_NP_WB;
         end
         S_NP_WB: begin
            if (mul_done) begin
               work_we    = 1'b1;
               work_wdata = sub_mod(prev_ff, mul_res, m_eff);
               prev_in    = val_ff;
               if (k_ff == j_ff + 1'b1) begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_NP_RDJ;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_NP_RDK;
               end
            end
         end
         // per point: fetch x_i and y_i
         S_LI_RD: begin
            if (i_ff == cnt_ff) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               state_in = S_LI_LD;
            end
         end
         S_LI_LD: begin
            xi_in    = pts_rdata.x;
            yi_in    = pts_rdata.y;
            acc_in   = '0;
            k_in     = cnt_ff;
            state_in = S_SD_RD;
         end
         // synthetic division by (t - x_i), high power downward
         S_SD_RD: begin
            state_in = S_SD_MUL;
         end
         S_SD_MUL: begin
            val_in    = work_rdata;
            mul_start = 1'b1;
            mul_a     = acc_ff;
            mul_b     = xi_ff;
            state_in  = S_SD_WB;
         end
         S_SD_WB: begin
            if (mul_done) begin
               acc_in     = nacc;
               work_we    = 1'b1;
               work_waddr = q_addr(km1);
               work_wdata = nacc;
               if (k_ff == KW'(1)) begin
                  acc_in   = one;
                  j_in     = '0;
                  state_in = S_DN_RD;
               end else begin
                  k_in     = km1;
                  state_in = S_SD_RD;
               end
            end
         end
         // denominator: product of (x_i - x_j) over j other than i
         S_DN_RD: begin
            pts_raddr = j_ff[IDX_W-1:0];
            if (j_ff == cnt_ff) begin
               base_in  = acc_ff;
               acc_in   = one;
               exp_in   = (m_eff >= VALUE_BITS'(2)) ? m_eff - VALUE_BITS'(2) : '0;
               state_in = S_PW_CHK;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_DN_MUL;
            end
         end
         S_DN_MUL: begin
            mul_start = 1'b1;
            mul_a     = acc_ff;
            mul_b     = sub_mod(xi_ff, pts_rdata.x, m_eff);
            state_in  = S_DN_WB;
         end
         S_DN_WB: begin
            if (mul_done) begin
               acc_in   = mul_res;
               j_in     = j_ff + 1'b1;
               state_in = S_DN_RD;
            end
         end
         // fermat inverse, square and multiply from the low exponent bit
         S_PW_CHK: begin
            mul_start = 1'b1;
            if (exp_ff == '0) begin
               mul_a    = acc_ff;
               mul_b    = yi_ff;
               state_in = S_SC_W;
            end else if (exp_ff[0]) begin
               mul_a    = acc_ff;
               mul_b    = base_ff;
               state_in = S_PW_R;
            end else begin
               mul_a    = base_ff;
               mul_b    = base_ff;
               state_in = S_PW_B;
            end
         end
         S_PW_R: begin
            if (mul_done) begin
               acc_in    = mul_res;
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = S_PW_B;
            end
         end
         S_PW_B: begin
            if (mul_done) begin
               base_in  = mul_res;
               exp_in   = {1'b0, exp_ff[VALUE_BITS-1:1]};
               state_in = S_PW_CHK;
            end
         end
         // scale factor y_i / d
         S_SC_W: begin
            if (mul_done) begin
               s_in     = mul_res;
               k_in     = '0;
               state_in = S_AC_RQ;
            end
         end
         // add the scaled quotient into the sums
         S_AC_RQ: begin
            work_raddr = q_addr(k_ff);
            if (k_ff == cnt_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_LI_RD;
            end else begin
               state_in = S_AC_MUL;
            end
         end
         S_AC_MUL: begin
            work_raddr = cs_addr(k_ff);
            mul_start  = 1'b1;
            mul_a      = work_rdata;
            mul_b      = s_ff;
            state_in   = S_AC_LDC;
         end
         S_AC_LDC: begin
            val_in   = work_rdata;
            state_in = S_AC_WB;
         end
         S_AC_WB: begin
            if (mul_done) begin
               work_we    = 1'b1;
               work_waddr = cs_addr(k_ff);
               work_wdata = add_mod(val_ff, mul_res, m_eff);
               k_in       = k_ff + 1'b1;
               state_in   = S_AC_RQ;
            end
         end
         // emit coefficient words, lowest power first
         S_OUT_RD: begin
            work_raddr = cs_addr(k_ff);
            if (k_ff == cnt_ff) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               rep_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_OUT_EM;
            end
         end
         S_OUT_EM: begin
            rsp_valid_in            = 1'b1;
            rsp_in.coefficient      = rep_ff ? '0 : work_rdata;
            rsp_in.power_index      = POWER_BITS'(k_ff);
            rsp_in.last_coefficient = (k_ff + 1'b1 == cnt_ff);
            rsp_in.repeated_x       = rep_ff;
            rsp_in.points_dropped   = ovf_ff;
            k_in                    = k_ff + 1'b1;
            state_in                = S_OUT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            prime_ff <= csr_write_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      in_y_ff    <= in_y_in;
      in_last_ff <= in_last_in;
      xi_ff      <= xi_in;
      yi_ff      <= yi_in;
      acc_ff     <= acc_in;
      base_ff    <= base_in;
      exp_ff     <= exp_in;
      prev_ff    <= prev_in;
      val_ff     <= val_in;
      s_ff       <= s_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // checks
   `MLI_ASSERT_HOLDS(a_word_only_in_drain, rsp_valid_ff, state_ff == S_OUT_RD, "result word outside output drain")
   `MLI_ASSERT_NEXT(a_last_word_frees, rsp_valid_ff && rsp_ff.last_coefficient, state_ff == S_IDLE, "block not idle after last coefficient")
   `MLI_ASSERT_NEXT(a_mul_not_instant, mul_start, !mul_done, "multiplier finished too early")
   `MLI_ASSERT_HOLDS(a_count_bound, 1'b1, cnt_ff <= KW'(MAX_POINTS), "point count beyond capacity")

endmodule

`default_nettype wire

@@ hdl/mli_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none

module mli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/mli_mulmod.sv @@
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`default_nettype none

module mli_mulmod import mli_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] a,
   input  wire logic [VALUE_BITS-1:0] b,
   input  wire logic [VALUE_BITS-1:0] modulus,
   output logic                       done,
   output logic      [VALUE_BITS-1:0] product
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [VALUE_BITS-1:0] m_ff, m_in;
   logic [VALUE_BITS-1:0] r_ff, r_in;
   logic [VALUE_BITS-1:0] r_dbl;

   // double the partial result, then add a when the multiplier bit is set
   always_comb begin
      r_dbl   = add_mod(r_ff, r_ff, m_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      if (busy_ff) begin
         r_in    = b_ff[VALUE_BITS-1] ? add_mod(r_dbl, a_ff, m_ff) : r_dbl;
         b_in    = {b_ff[VALUE_BITS-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = a;
         b_in    = b;
         m_in    = modulus;
         r_in    = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

`default_nettype wire
